@@ sv/bwx_pkg.sv @@
// shared constants and types for the bitwise repeating key xor block
`default_nettype none
package bwx_pkg;

  localparam int DATA_W     = 8;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int KEY_LEN_W  = 6;
  localparam int BIT_W      = 3;
  localparam int WORD_BYTES = 8;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3  = 3'd4;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd1;
  localparam logic [COUNT_W-1:0]   COUNT_MAX     = 4'd8;
  localparam logic [BIT_W-1:0]     BIT_FIRST     = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0] key_bits;   // drawn bits, packed into the low positions
    logic              to_next;    // cursor moves to the next key byte
    logic [BIT_W-1:0]  next_bit;   // cursor bit after the draw
  } draw_res_t;

endpackage
`default_nettype wire

@@ sv/bwx_if.sv @@
// valid/ready channel interfaces for input and result transactions
`default_nettype none
interface bwx_in_if
  import bwx_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  data_byte;
  logic [COUNT_W-1:0] bit_count;

  modport source (output valid, output data_byte, output bit_count, input ready);
  modport sink   (input valid, input data_byte, input bit_count, output ready);
endinterface

interface bwx_out_if
  import bwx_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result_byte;

  modport source (output valid, output result_byte, input ready);
  modport sink   (input valid, input result_byte, output ready);
endinterface
`default_nettype wire

@@ sv/bwx_key_regs.sv @@
// key configuration registers and effective key length
`default_nettype none
module bwx_key_regs
  import bwx_pkg::*;
#(
  parameter int KEY_BYTES = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  output logic      [KEY_BYTES*8-1:0]  key_bytes,
  output logic      [KEY_LEN_W-1:0]    eff_len,
  output logic                         cfg_hit
);

  logic [KEY_LEN_W-1:0]   key_len_r, key_len_nxt;
  logic [KEY_BYTES*8-1:0] key_r, key_nxt;

  always_comb begin
    key_len_nxt = key_len_r;
    key_nxt     = key_r;
    if (cfg_we) begin
      if (cfg_index == REG_KEY_LENGTH) begin
        key_len_nxt = cfg_data[KEY_LEN_W-1:0];
      end
      // only key bytes below KEY_BYTES are kept
      for (int b = 0; b < KEY_BYTES; b++) begin
        if (cfg_index == CFG_IDX_W'(int'(REG_KEY_WORD0) + b / WORD_BYTES)) begin
          key_nxt[b*8 +: 8] = cfg_data[(b % WORD_BYTES)*8 +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= KEY_LEN_RESET;
      key_r     <= '0;
    end else begin
      key_len_r <= key_len_nxt;
      key_r     <= key_nxt;
    end
  end

  // zero length acts as one, anything above the storage clamps to it
  always_comb begin
    if (key_len_r == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (key_len_r > KEY_LEN_W'(KEY_BYTES)) begin
      eff_len = KEY_LEN_W'(KEY_BYTES);
    end else begin
      eff_len = key_len_r;
    end
  end

  assign key_bytes = key_r;
  assign cfg_hit   = cfg_we && (cfg_index <= REG_KEY_WORD3);

endmodule
`default_nettype wire

@@ sv/bwx_draw.sv @@
// extracts the key bits for one byte from a two-byte key window
`default_nettype none
module bwx_draw
  import bwx_pkg::*;
(
  input  wire logic [7:0]         cur_key,
  input  wire logic [7:0]         nxt_key,
  input  wire logic [BIT_W-1:0]   cur_bit,
  input  wire logic [COUNT_W-1:0] bit_count,
  output draw_res_t               res
);

  logic [COUNT_W-1:0] cnt;
  logic [15:0]        win;
  logic [4:0]         shamt;
  logic [DATA_W-1:0]  mask;
  logic [3:0]         offset;
  logic [15:0]        shifted;

  always_comb begin
    cnt     = (bit_count > COUNT_MAX) ? COUNT_MAX : bit_count;
    win     = {cur_key, nxt_key};
    // first drawn bit sits at window position 8 + cur_bit
    shamt   = 5'd9 + 5'(cur_bit) - 5'(cnt);
    shifted = win >> shamt;
    mask    = DATA_W'((9'd1 << cnt) - 9'd1);
    offset  = (4'd7 - 4'(cur_bit)) + cnt;

    res.key_bits = shifted[DATA_W-1:0] & mask;
    res.to_next  = offset[3];
    res.next_bit = ~offset[2:0];
  end

endmodule
`default_nettype wire

@@ sv/bitwise_repeating_key_xor.sv @@
// top level of the bitwise repeating key xor cipher
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------
//  in_ch    | in  | valid/ready        | data_byte[7:0], bit_count[3:0]
//  out_ch   | out | valid/ready        | result_byte[7:0]
//  cfg_*    | in  | write enable only  | cfg_index[2:0], cfg_data[63:0]
//
// one byte per cycle sustained while out_ch takes results; a result passes through
// the input register and then the result register after its input transaction.
// the bit cursor advances when an item leaves the input register.
// synchronous active-low reset clears valids and key bytes, sets key length 1, cursor to byte 0 bit 7.
// a stalled result holds in the output register while one more item waits.
`default_nettype none
module bitwise_repeating_key_xor
  import bwx_pkg::*;
#(
  parameter int KEY_BYTES = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bwx_in_if.sink                     in_ch,
  bwx_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CUR_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  logic [KEY_BYTES*8-1:0] key_bytes;
  logic [KEY_LEN_W-1:0]   eff_len;
  logic                   cfg_hit;

  logic                   s1_v_r;
  logic [DATA_W-1:0]      s1_data_r;
  logic [COUNT_W-1:0]     s1_cnt_r;
  logic                   out_v_r;
  logic [DATA_W-1:0]      out_data_r;
  logic [CUR_W-1:0]       cur_byte_r, cur_byte_nxt;
  logic [BIT_W-1:0]       cur_bit_r, cur_bit_nxt;

  logic                   s2_load;
  logic                   in_take;
  logic [KEY_LEN_W-1:0]   byte_inc;
  logic [CUR_W-1:0]       next_byte;
  logic [7:0]             cur_key, nxt_key;
  draw_res_t              draw;

  bwx_key_regs #(
    .KEY_BYTES (KEY_BYTES)
  ) u_key_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key_bytes (key_bytes),
    .eff_len   (eff_len),
    .cfg_hit   (cfg_hit)
  );

  // key byte after the cursor, wrapping at the key length
  assign byte_inc  = KEY_LEN_W'(cur_byte_r) + KEY_LEN_W'(1);
  assign next_byte = (byte_inc >= eff_len) ? '0 : byte_inc[CUR_W-1:0];
  assign cur_key   = key_bytes[{cur_byte_r, 3'b000} +: 8];
  assign nxt_key   = key_bytes[{next_byte, 3'b000} +: 8];

  bwx_draw u_draw (
    .cur_key   (cur_key),
    .nxt_key   (nxt_key),
    .cur_bit   (cur_bit_r),
    .bit_count (s1_cnt_r),
    .res       (draw)
  );

  assign s2_load     = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s2_load;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    cur_byte_nxt = cur_byte_r;
    cur_bit_nxt  = cur_bit_r;
    if (cfg_hit) begin
      cur_byte_nxt = '0;
      cur_bit_nxt  = BIT_FIRST;
    end else if (s2_load) begin
      cur_bit_nxt = draw.next_bit;
      if (draw.to_next) begin
        cur_byte_nxt = next_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      cur_byte_r <= '0;
      cur_bit_r  <= BIT_FIRST;
    end else begin
      cur_byte_r <= cur_byte_nxt;
      cur_bit_r  <= cur_bit_nxt;
      if (in_take) begin
        s1_v_r <= 1'b1;
      end else if (s2_load) begin
        s1_v_r <= 1'b0;
      end
      if (s2_load) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_ch.data_byte;
      s1_cnt_r  <= in_ch.bit_count;
    end
    if (s2_load) begin
      out_data_r <= s1_data_r ^ draw.key_bits;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.result_byte = out_data_r;

endmodule
`default_nettype wire

@@ sv/bwx_checker.sv @@
// port-level assertions for the cipher top level, with its bind
`default_nettype none
module bwx_checker
  import bwx_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DATA_W-1:0] result_byte
);

  // a waiting result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  // a waiting result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(result_byte))
    else $error("result byte changed while stalled");

  // no backpressure on the input side while the result side drains
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is ready");

  // an accepted transaction reaches the output when the output side takes results
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted transaction did not reach the output");

endmodule

bind bitwise_repeating_key_xor bwx_checker u_bwx_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .result_byte (out_ch.result_byte)
);
`default_nettype wire
